[rtl/sisu_pkg.sv]
// Shared types and codes for the set intersection and union core.
package sisu_pkg;

    localparam int unsigned ELEM_W = 32;

    // Request commands.
    localparam logic [1:0] CMD_LOAD_A = 2'd0;
    localparam logic [1:0] CMD_LOAD_B = 2'd1;
    localparam logic [1:0] CMD_START  = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_ISECT = 2'd1;
    localparam logic [1:0] KIND_UNION = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    // Load status codes.
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_DUP  = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    // What a probe does when it leaves the chain.
    typedef enum logic [1:0] {
        POL_ACK,
        POL_HIT,
        POL_MISS,
        POL_ALL
    } pol_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        PH_ISECT,
        PH_UNION_B,
        PH_UNION_A
    } phase_t;

    // A membership probe travelling along the cell chain.
    typedef struct packed {
        logic              valid;
        logic [ELEM_W-1:0] value;
        logic              sel_b;
        pol_t              pol;
        logic              hit;
    } probe_t;

endpackage

[rtl/set_intersection_union_core.sv]
// Top level of the set intersection and union core: controller and cell chain.
// A load request sends one probe down a chain of SET_DEPTH cells, each holding one entry of
// set A and one of set B; the next request is taken only after its acknowledge is produced.
// A start request feeds one probe per cycle into the chain while the result port does not
// stall: one for each member of the smaller set, each of B and each of A, then waits for the
// chain to empty and sends the final result. A stalled result port freezes the chain.
module set_intersection_union_core #(
    parameter int unsigned SET_DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic signed [31:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic signed [31:0] m_element,
    output logic [1:0]         m_status,
    output logic               m_last
);

    localparam int unsigned CW = $clog2(SET_DEPTH + 1);
    localparam int unsigned IW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int unsigned EW = sisu_pkg::ELEM_W;

    sisu_pkg::state_t state_reg, state_next;
    sisu_pkg::phase_t phase_reg, phase_next;
    logic [CW-1:0]    j_reg, j_next;
    logic [CW-1:0]    dcnt_reg, dcnt_next;
    logic [CW-1:0]    cnt_a_reg, cnt_a_next;
    logic [CW-1:0]    cnt_b_reg, cnt_b_next;
    logic             held_valid_reg, held_valid_next;
    logic [EW-1:0]    held_elem_reg, held_elem_next;
    logic [1:0]       held_kind_reg, held_kind_next;
    logic             m_valid_reg, m_valid_next;
    logic [1:0]       m_kind_reg, m_kind_next;
    logic [EW-1:0]    m_elem_reg, m_elem_next;
    logic [1:0]       m_status_reg, m_status_next;
    logic             m_last_reg, m_last_next;

    logic             adv;
    logic             accept;
    logic             wr_a;
    logic             wr_b;
    logic             s_is_b;
    logic             emit;
    logic [CW-1:0]    sel_cnt;
    logic [1:0]       ack_status;
    sisu_pkg::probe_t iss;
    sisu_pkg::probe_t exit_probe;

    sisu_pkg::probe_t chain [0:SET_DEPTH];
    logic [EW-1:0]    a_val [0:SET_DEPTH-1];
    logic [EW-1:0]    b_val [0:SET_DEPTH-1];
    logic [SET_DEPTH-1:0] pv;

    // The output register frees up, so the whole chain may shift.
    assign adv        = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == sisu_pkg::ST_IDLE) && adv;
    assign accept     = s_valid && s_ready;
    assign chain[0]   = iss;
    assign exit_probe = chain[SET_DEPTH];
    assign s_is_b     = cnt_a_reg > cnt_b_reg;

    genvar gi;
    generate
        for (gi = 0; gi < SET_DEPTH; gi++) begin : g_cell
            sisu_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .adv       (adv),
                .a_live    (CW'(gi) < cnt_a_reg),
                .b_live    (CW'(gi) < cnt_b_reg),
                .a_we      (wr_a && (cnt_a_reg == CW'(gi))),
                .b_we      (wr_b && (cnt_b_reg == CW'(gi))),
                .wr_value  (exit_probe.value),
                .probe_in  (chain[gi]),
                .probe_out (chain[gi+1]),
                .a_value   (a_val[gi]),
                .b_value   (b_val[gi])
            );
            assign pv[gi] = chain[gi+1].valid;
        end
    endgenerate

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        j_next          = j_reg;
        dcnt_next       = dcnt_reg;
        cnt_a_next      = cnt_a_reg;
        cnt_b_next      = cnt_b_reg;
        held_valid_next = held_valid_reg;
        held_elem_next  = held_elem_reg;
        held_kind_next  = held_kind_reg;
        m_valid_next    = m_valid_reg;
        m_kind_next     = m_kind_reg;
        m_elem_next     = m_elem_reg;
        m_status_next   = m_status_reg;
        m_last_next     = m_last_reg;
        wr_a            = 1'b0;
        wr_b            = 1'b0;
        emit            = 1'b0;
        ack_status      = sisu_pkg::STAT_OK;
        sel_cnt         = exit_probe.sel_b ? cnt_b_reg : cnt_a_reg;
        iss             = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            sisu_pkg::ST_IDLE: begin
                if (accept) begin
                    case (s_cmd)
                        sisu_pkg::CMD_LOAD_A, sisu_pkg::CMD_LOAD_B: begin
                            iss.valid  = 1'b1;
                            iss.value  = s_value;
                            iss.sel_b  = (s_cmd == sisu_pkg::CMD_LOAD_B);
                            iss.pol    = sisu_pkg::POL_ACK;
                            state_next = sisu_pkg::ST_LOAD;
                        end
                        sisu_pkg::CMD_START: begin
                            phase_next = sisu_pkg::PH_ISECT;
                            j_next     = '0;
                            state_next = sisu_pkg::ST_ISSUE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            sisu_pkg::ST_LOAD: begin
            end
            sisu_pkg::ST_ISSUE: begin
                if (adv) begin
                    case (phase_reg)
                        sisu_pkg::PH_ISECT: begin
                            if (j_reg < (s_is_b ? cnt_b_reg : cnt_a_reg)) begin
                                iss.valid = 1'b1;
                                iss.value = s_is_b ? b_val[j_reg[IW-1:0]]
                                                   : a_val[j_reg[IW-1:0]];
                                iss.sel_b = !s_is_b;
                                iss.pol   = sisu_pkg::POL_HIT;
                                j_next    = j_reg + 1'b1;
                            end else begin
                                phase_next = sisu_pkg::PH_UNION_B;
                                j_next     = '0;
                            end
                        end
                        sisu_pkg::PH_UNION_B: begin
                            if (j_reg < cnt_b_reg) begin
                                iss.valid = 1'b1;
                                iss.value = b_val[j_reg[IW-1:0]];
                                iss.sel_b = 1'b1;
                                iss.pol   = sisu_pkg::POL_ALL;
                                j_next    = j_reg + 1'b1;
                            end else begin
                                phase_next = sisu_pkg::PH_UNION_A;
                                j_next     = '0;
                            end
                        end
                        default: begin
                            if (j_reg < cnt_a_reg) begin
                                iss.valid = 1'b1;
                                iss.value = a_val[j_reg[IW-1:0]];
                                iss.sel_b = 1'b1;
                                iss.pol   = sisu_pkg::POL_MISS;
                                j_next    = j_reg + 1'b1;
                            end else begin
                                dcnt_next  = '0;
                                state_next = sisu_pkg::ST_DRAIN;
                            end
                        end
                    endcase
                end
            end
            sisu_pkg::ST_DRAIN: begin
                if (adv) begin
                    if (dcnt_reg == CW'(SET_DEPTH - 1)) begin
                        state_next = sisu_pkg::ST_FINISH;
                    end else begin
                        dcnt_next = dcnt_reg + 1'b1;
                    end
                end
            end
            sisu_pkg::ST_FINISH: begin
                if (adv) begin
                    m_valid_next  = 1'b1;
                    m_status_next = sisu_pkg::STAT_OK;
                    m_last_next   = 1'b1;
                    if (held_valid_reg) begin
                        m_kind_next = held_kind_reg;
                        m_elem_next = held_elem_reg;
                    end else begin
                        m_kind_next = sisu_pkg::KIND_DONE;
                        m_elem_next = '0;
                    end
                    held_valid_next = 1'b0;
                    cnt_a_next      = '0;
                    cnt_b_next      = '0;
                    state_next      = sisu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sisu_pkg::ST_IDLE;
            end
        endcase

        // A probe leaves the last cell.
        if (adv && exit_probe.valid) begin
            if (exit_probe.pol == sisu_pkg::POL_ACK) begin
                if (exit_probe.hit) begin
                    ack_status = sisu_pkg::STAT_DUP;
                end else if (sel_cnt == CW'(SET_DEPTH)) begin
                    ack_status = sisu_pkg::STAT_FULL;
                end else begin
                    ack_status = sisu_pkg::STAT_OK;
                    wr_a       = !exit_probe.sel_b;
                    wr_b       = exit_probe.sel_b;
                end
                if (wr_a) begin
                    cnt_a_next = cnt_a_reg + 1'b1;
                end
                if (wr_b) begin
                    cnt_b_next = cnt_b_reg + 1'b1;
                end
                m_valid_next  = 1'b1;
                m_kind_next   = sisu_pkg::KIND_ACK;
                m_elem_next   = '0;
                m_status_next = ack_status;
                m_last_next   = 1'b1;
                state_next    = sisu_pkg::ST_IDLE;
            end else begin
                emit = (exit_probe.pol == sisu_pkg::POL_ALL)
                    || ((exit_probe.pol == sisu_pkg::POL_HIT) && exit_probe.hit)
                    || ((exit_probe.pol == sisu_pkg::POL_MISS) && !exit_probe.hit);
                // One result is held back so that the final one can carry last.
                if (emit) begin
                    if (held_valid_reg) begin
                        m_valid_next  = 1'b1;
                        m_kind_next   = held_kind_reg;
                        m_elem_next   = held_elem_reg;
                        m_status_next = sisu_pkg::STAT_OK;
                        m_last_next   = 1'b0;
                    end
                    held_valid_next = 1'b1;
                    held_elem_next  = exit_probe.value;
                    held_kind_next  = (exit_probe.pol == sisu_pkg::POL_HIT)
                                    ? sisu_pkg::KIND_ISECT : sisu_pkg::KIND_UNION;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= sisu_pkg::ST_IDLE;
            phase_reg      <= sisu_pkg::PH_ISECT;
            j_reg          <= '0;
            dcnt_reg       <= '0;
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            held_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            j_reg          <= j_next;
            dcnt_reg       <= dcnt_next;
            cnt_a_reg      <= cnt_a_next;
            cnt_b_reg      <= cnt_b_next;
            held_valid_reg <= held_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_elem_reg <= held_elem_next;
        held_kind_reg <= held_kind_next;
        m_kind_reg    <= m_kind_next;
        m_elem_reg    <= m_elem_next;
        m_status_reg  <= m_status_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_kind    = m_kind_reg;
    assign m_element = $signed(m_elem_reg);
    assign m_status  = m_status_reg;
    assign m_last    = m_last_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_a_reg <= CW'(SET_DEPTH)) && (cnt_b_reg <= CW'(SET_DEPTH)))
        else $error("set count above depth");

    a_single_load_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sisu_pkg::ST_LOAD) |-> ($countones(pv) <= 1))
        else $error("more than one probe in flight during a load");

    a_ack_in_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (exit_probe.valid && (exit_probe.pol == sisu_pkg::POL_ACK))
            |-> (state_reg == sisu_pkg::ST_LOAD))
        else $error("load probe left the chain outside a load");

    a_idle_no_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sisu_pkg::ST_IDLE) |-> !held_valid_reg)
        else $error("held result left behind when idle");

    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == sisu_pkg::ST_FINISH) && adv)
            |=> ((cnt_a_reg == '0) && (cnt_b_reg == '0)))
        else $error("sets not emptied after a start request");
`endif

endmodule

[rtl/sisu_cell.sv]
// One chain cell: holds one entry of each set and checks passing probes against it.
module sisu_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                adv,
    input  logic                                a_live,
    input  logic                                b_live,
    input  logic                                a_we,
    input  logic                                b_we,
    input  logic [sisu_pkg::ELEM_W-1:0]         wr_value,
    input  sisu_pkg::probe_t                    probe_in,
    output sisu_pkg::probe_t                    probe_out,
    output logic [sisu_pkg::ELEM_W-1:0]         a_value,
    output logic [sisu_pkg::ELEM_W-1:0]         b_value
);

    logic [sisu_pkg::ELEM_W-1:0] a_reg;
    logic [sisu_pkg::ELEM_W-1:0] b_reg;
    sisu_pkg::probe_t            probe_reg;
    sisu_pkg::probe_t            probe_next;
    logic                        match;

    always_comb begin
        if (probe_in.sel_b) begin
            match = b_live && (b_reg == probe_in.value);
        end else begin
            match = a_live && (a_reg == probe_in.value);
        end
        probe_next     = probe_in;
        probe_next.hit = probe_in.hit | (probe_in.valid & match);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg.valid <= 1'b0;
        end else if (adv) begin
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_we) begin
            a_reg <= wr_value;
        end
        if (b_we) begin
            b_reg <= wr_value;
        end
    end

    assign probe_out = probe_reg;
    assign a_value   = a_reg;
    assign b_value   = b_reg;

endmodule

[tb/tb_set_intersection_union_core.sv]
// Self-checking testbench for the set intersection and union core.
module tb_set_intersection_union_core;

    localparam int unsigned SET_DEPTH      = 16;
    localparam logic [1:0]  CMD_UNDEF      = 2'd3;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          END_DRAIN      = 4 * SET_DEPTH + 16;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          PHASE_ITEMS    = 50;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] value;
    } request_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] element;
        logic [1:0]  status;
        logic        last;
    } result_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [1:0]         s_cmd     = sisu_pkg::CMD_LOAD_A;
    logic signed [31:0] s_value   = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic [1:0]         m_kind;
    logic signed [31:0] m_element;
    logic [1:0]         m_status;
    logic               m_last;

    request_t pending_requests[$];
    result_t  expected_results[$];

    // Shadow copy of the two sets, updated as each request is accepted.
    logic [31:0] shadow_a [SET_DEPTH];
    logic [31:0] shadow_b [SET_DEPTH];
    int unsigned count_a = 0;
    int unsigned count_b = 0;

    int mismatches    = 0;
    int queued_items  = 0;
    int send_idle_pct = 16;
    int recv_idle_pct = 50;
    int idle_phase    = 0;
    int quiet_cycles  = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    set_intersection_union_core #(
        .SET_DEPTH(SET_DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_cmd    (s_cmd),
        .s_value  (s_value),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_kind   (m_kind),
        .m_element(m_element),
        .m_status (m_status),
        .m_last   (m_last)
    );

    always #5 aclk = ~aclk;

    function automatic bit holds(input bit sel_b, input logic [31:0] v);
        int unsigned i;
        if (sel_b) begin
            for (i = 0; i < count_b; i++)
                if (shadow_b[i] == v) return 1'b1;
        end else begin
            for (i = 0; i < count_a; i++)
                if (shadow_a[i] == v) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [1:0] add_member(input bit sel_b, input logic [31:0] v);
        if (holds(sel_b, v)) return sisu_pkg::STAT_DUP;
        if (sel_b) begin
            if (count_b >= SET_DEPTH) return sisu_pkg::STAT_FULL;
            shadow_b[count_b] = v;
            count_b = count_b + 1;
        end else begin
            if (count_a >= SET_DEPTH) return sisu_pkg::STAT_FULL;
            shadow_a[count_a] = v;
            count_a = count_a + 1;
        end
        return sisu_pkg::STAT_OK;
    endfunction

    function automatic void expect_result(input logic [1:0] kind, input logic [31:0] elem,
                                          input logic [1:0] st);
        result_t r;
        r.kind    = kind;
        r.element = elem;
        r.status  = st;
        r.last    = 1'b0;
        expected_results = {expected_results, r};
    endfunction

    function automatic void predict_request(input logic [1:0] cmd, input logic [31:0] value);
        int          first;
        int unsigned i;
        first = expected_results.size();
        if (cmd == sisu_pkg::CMD_LOAD_A || cmd == sisu_pkg::CMD_LOAD_B) begin
            expect_result(sisu_pkg::KIND_ACK, '0,
                          add_member(cmd == sisu_pkg::CMD_LOAD_B, value));
        end else if (cmd == sisu_pkg::CMD_START) begin
            // The intersection walks the smaller set; B wins only when A is strictly larger.
            if (count_a > count_b) begin
                for (i = 0; i < count_b; i++)
                    if (holds(1'b0, shadow_b[i]))
                        expect_result(sisu_pkg::KIND_ISECT, shadow_b[i], sisu_pkg::STAT_OK);
            end else begin
                for (i = 0; i < count_a; i++)
                    if (holds(1'b1, shadow_a[i]))
                        expect_result(sisu_pkg::KIND_ISECT, shadow_a[i], sisu_pkg::STAT_OK);
            end
            for (i = 0; i < count_b; i++)
                expect_result(sisu_pkg::KIND_UNION, shadow_b[i], sisu_pkg::STAT_OK);
            for (i = 0; i < count_a; i++)
                if (!holds(1'b1, shadow_a[i]))
                    expect_result(sisu_pkg::KIND_UNION, shadow_a[i], sisu_pkg::STAT_OK);
            if (expected_results.size() == first)
                expect_result(sisu_pkg::KIND_DONE, '0, sisu_pkg::STAT_OK);
            count_a = 0;
            count_b = 0;
        end
        if (expected_results.size() > first) begin
            expected_results[expected_results.size() - 1].last = 1'b1;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches = mismatches + 1;
        if (mismatches <= 40) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic queue_request(input logic [1:0] cmd, input logic [31:0] value);
        request_t req;
        req.cmd   = cmd;
        req.value = value;
        pending_requests = {pending_requests, req};
        if (cmd != CMD_UNDEF) queued_items = queued_items + 1;
    endtask

    function automatic logic [31:0] pick_value(input logic [31:0] base, input bit pooled);
        logic [31:0] v;
        if (pooled) v = base + $urandom_range(0, 7);
        else v = $urandom;
        return v;
    endfunction

    // One batch of loads ending in a start, a set filled past its depth, or plain noise.
    task automatic queue_sequence();
        int          shape;
        int          left_a;
        int          left_b;
        int          n;
        int          i;
        logic [31:0] base;
        bit          pooled;
        logic [1:0]  cmd_sel;
        logic [1:0]  cmd_other;
        shape  = $urandom_range(0, 9);
        base   = $urandom;
        pooled = ($urandom_range(0, 9) < 7);
        if (shape == 9) begin
            n = $urandom_range(2, 5);
            for (i = 0; i < n; i++)
                queue_request(2'($urandom_range(0, 3)), $urandom);
        end else if (shape >= 7) begin
            cmd_sel   = $urandom_range(0, 1) ? sisu_pkg::CMD_LOAD_B : sisu_pkg::CMD_LOAD_A;
            cmd_other = (cmd_sel == sisu_pkg::CMD_LOAD_B) ? sisu_pkg::CMD_LOAD_A
                                                          : sisu_pkg::CMD_LOAD_B;
            for (i = 0; i < SET_DEPTH; i++)
                queue_request(cmd_sel, base + i);
            queue_request(cmd_sel, base + SET_DEPTH);
            queue_request(cmd_sel, base + $urandom_range(0, SET_DEPTH - 1));
            if ($urandom_range(0, 1)) begin
                for (i = 0; i < SET_DEPTH; i++)
                    queue_request(cmd_other, base + SET_DEPTH / 2 + i);
            end else begin
                for (i = 0; i < 3; i++)
                    queue_request(cmd_other, pick_value(base, 1'b1));
            end
            queue_request(sisu_pkg::CMD_START, $urandom);
        end else begin
            left_a = $urandom_range(0, 6);
            left_b = $urandom_range(0, 6);
            while (left_a + left_b > 0) begin
                if ($urandom_range(0, 9) == 0) queue_request(CMD_UNDEF, $urandom);
                if (left_b == 0 || (left_a != 0 && $urandom_range(0, 1))) begin
                    queue_request(sisu_pkg::CMD_LOAD_A, pick_value(base, pooled));
                    left_a = left_a - 1;
                end else begin
                    queue_request(sisu_pkg::CMD_LOAD_B, pick_value(base, pooled));
                    left_b = left_b - 1;
                end
            end
            queue_request(sisu_pkg::CMD_START, $urandom);
        end
    endtask

    task automatic queue_random_items(input int target);
        int start_count;
        start_count = queued_items;
        while (queued_items - start_count < target) queue_sequence();
    endtask

    task automatic wait_requests_sent();
        while (pending_requests.size() != 0 || s_valid) @(negedge aclk);
    endtask

    // Request driver.
    always @(posedge aclk) begin : driver
        request_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                req = pending_requests.pop_front();
                s_valid <= 1'b1;
                s_cmd   <= req.cmd;
                s_value <= req.value;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver; it holds off once for a long stretch when the last phase begins.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (!hold_done && idle_phase == 2) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: predict on each accepted request, check each accepted result.
    always @(posedge aclk) begin : monitor
        result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) predict_request(s_cmd, s_value);
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d element %0d",
                                              m_kind, m_element));
                end else begin
                    want = expected_results.pop_front();
                    if (m_kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, expected %0d", m_kind, want.kind));
                    if (m_element !== want.element)
                        report_mismatch($sformatf("element %h, expected %h",
                                                  m_element, want.element));
                    if (m_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_status, want.status));
                    if (m_last !== want.last)
                        report_mismatch($sformatf("last %0d, expected %0d", m_last, want.last));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        @(posedge aclk);
        @(posedge aclk);
        aresetn <= 1'b1;

        // Start with both sets empty, then value extremes, duplicates and an undefined command.
        queue_request(sisu_pkg::CMD_START, 32'h0);
        queue_request(sisu_pkg::CMD_LOAD_A, 32'h8000_0000);
        queue_request(sisu_pkg::CMD_LOAD_A, 32'h7FFF_FFFF);
        queue_request(sisu_pkg::CMD_LOAD_A, 32'h0000_0000);
        queue_request(sisu_pkg::CMD_LOAD_A, 32'hFFFF_FFFF);
        queue_request(sisu_pkg::CMD_LOAD_A, 32'h0000_0000);
        queue_request(sisu_pkg::CMD_LOAD_B, 32'h0000_0000);
        queue_request(sisu_pkg::CMD_LOAD_B, 32'h7FFF_FFFF);
        queue_request(sisu_pkg::CMD_LOAD_B, 32'h0000_0005);
        queue_request(sisu_pkg::CMD_LOAD_B, 32'h0000_0005);
        queue_request(CMD_UNDEF, 32'hFFFF_FFFF);
        queue_request(sisu_pkg::CMD_START, 32'hFFFF_FFFF);
        // Only B loaded: no intersection, union items alone.
        queue_request(sisu_pkg::CMD_LOAD_B, 32'h0000_0007);
        queue_request(sisu_pkg::CMD_START, 32'h5555_AAAA);

        queue_random_items(PHASE_ITEMS);
        wait_requests_sent();

        send_idle_pct = 50;
        recv_idle_pct = 16;
        idle_phase    = 1;
        queue_random_items(PHASE_ITEMS);
        wait_requests_sent();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        idle_phase    = 2;
        queue_random_items(PHASE_ITEMS);
        wait_requests_sent();

        while (expected_results.size() != 0) @(negedge aclk);
        repeat (END_DRAIN) @(negedge aclk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
